FILE: rtl/tmac_pkg.sv
// Shared types, command codes and bit helpers for the TRIAD-MAC tag engine.
package tmac_pkg;

  // Command codes of an input beat
  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_ABSORB = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  // Configuration register indexes
  localparam logic CFG_KEY_LOW  = 1'b0;
  localparam logic CFG_KEY_HIGH = 1'b1;

  localparam int LEN_A  = 80;
  localparam int LEN_BC = 88;

  // Vector bit p-1 holds register position p
  typedef struct packed {
    logic [LEN_A-1:0]  a;
    logic [LEN_BC-1:0] b;
    logic [LEN_BC-1:0] c;
  } tmac_state_t;

  // Byte bit 7 sits at the lowest position of its byte slot
  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

endpackage

FILE: rtl/tmac_round.sv
// One round of the TRIAD permutation: feedback taps, keystream bit and shift.
module tmac_round (
  input  tmac_pkg::tmac_state_t st,
  input  logic                  m,
  output tmac_pkg::tmac_state_t st_nxt,
  output logic                  z
);

  logic t1;
  logic t2;
  logic t3;

  // Linear and nonlinear feedback terms
  always_comb begin
    t1 = st.a[67] ^ st.a[79] ^ (st.b[84] & st.c[84]);
    t2 = st.b[63] ^ st.b[87];
    t3 = st.c[67] ^ st.c[87];
    z  = t1 ^ t2 ^ t3;
    t1 = t1 ^ (st.a[72] & st.a[78]) ^ st.b[65] ^ m;
    t2 = t2 ^ (st.b[64] & st.b[86]) ^ st.c[83] ^ m;
    t3 = t3 ^ (st.c[76] & st.c[86]) ^ st.a[73] ^ m;
  end

  // Every register moves up one position; A takes t3, B takes t1, C takes t2
  assign st_nxt.a = {st.a[tmac_pkg::LEN_A-2:0], t3};
  assign st_nxt.b = {st.b[tmac_pkg::LEN_BC-2:0], t1};
  assign st_nxt.c = {st.c[tmac_pkg::LEN_BC-2:0], t2};

endmodule

FILE: rtl/triad_mac_engine.sv
// TRIAD-MAC tag engine top level: sequencer, state, key and result register.
// One permutation round runs per cycle through a single shared round unit.
// Start loads key and nonce, then permutes; absorb runs one round per data
// bit; finish permutes, then squeezes one tag bit per round; unused: no rounds.
// Input is stalled while an item is in work; the result register frees it.
// rst_n (synchronous, active low) zeroes the state, the keys and all control.
module triad_mac_engine #(
  parameter int PERMUTATION_ROUNDS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_data_byte,
  input  logic [63:0] in_nonce_low,
  input  logic [31:0] in_nonce_high,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_tag,
  output logic        out_tag_valid
);

  localparam int CNT_W = $clog2(PERMUTATION_ROUNDS + 64);
  localparam logic [CNT_W-1:0] START_LAST = CNT_W'(PERMUTATION_ROUNDS - 1);
  localparam logic [CNT_W-1:0] ABS_LAST   = CNT_W'(7);
  localparam logic [CNT_W-1:0] FIN_LAST   = CNT_W'(PERMUTATION_ROUNDS + 63);
  localparam logic [CNT_W-1:0] SQZ_FIRST  = CNT_W'(PERMUTATION_ROUNDS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]              fsm_r, fsm_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        lim_r, lim_nxt;
  logic [1:0]              cmd_r, cmd_nxt;
  logic [7:0]              data_r, data_nxt;
  logic [63:0]             key_low_r, key_high_r;
  tmac_pkg::tmac_state_t   st_r, st_nxt;
  logic [63:0]             tag_r, tag_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [63:0]             out_tag_r, out_tag_nxt;
  logic                    out_tag_valid_r, out_tag_valid_nxt;

  logic                    in_acc;
  logic                    slot_free;
  logic                    round_m;
  logic                    round_z;
  logic                    squeeze;
  tmac_pkg::tmac_state_t   round_out;
  tmac_pkg::tmac_state_t   load_st;
  logic [127:0]            key_all;
  logic [95:0]             nonce_all;

  assign in_stall  = (fsm_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_tag       = out_tag_r;
  assign out_tag_valid = out_tag_valid_r;

  // Initial state for a start beat: key, nonce and the constant bytes
  assign key_all   = {key_high_r, key_low_r};
  assign nonce_all = {in_nonce_high, in_nonce_low};
  always_comb begin
    load_st.a = {tmac_pkg::rev8(key_all[7:0]),   tmac_pkg::rev8(8'hFE),
                 tmac_pkg::rev8(key_all[15:8]),  tmac_pkg::rev8(8'hFF),
                 tmac_pkg::rev8(key_all[23:16]), tmac_pkg::rev8(8'hFF),
                 tmac_pkg::rev8(key_all[31:24]), tmac_pkg::rev8(8'hFF),
                 tmac_pkg::rev8(key_all[39:32]), tmac_pkg::rev8(nonce_all[7:0])};
    for (int i = 0; i < 11; i++) begin
      load_st.b[8*i +: 8] = tmac_pkg::rev8(nonce_all[8*(11-i) +: 8]);
      load_st.c[8*i +: 8] = tmac_pkg::rev8(key_all[8*(15-i) +: 8]);
    end
  end

  // Round input bit: one on the first permutation round, data bits on absorb
  always_comb begin
    if (cmd_r == tmac_pkg::CMD_ABSORB) begin
      round_m = data_r[cnt_r[2:0]];
    end else begin
      round_m = (cnt_r == '0);
    end
  end

  assign squeeze = (cmd_r == tmac_pkg::CMD_FINISH) && (cnt_r >= SQZ_FIRST);

  tmac_round u_round (
    .st     (st_r),
    .m      (round_m),
    .st_nxt (round_out),
    .z      (round_z)
  );

  // Sequencer
  always_comb begin
    fsm_nxt           = fsm_r;
    cnt_nxt           = cnt_r;
    lim_nxt           = lim_r;
    cmd_nxt           = cmd_r;
    data_nxt          = data_r;
    st_nxt            = st_r;
    tag_nxt           = tag_r;
    out_valid_nxt     = out_valid_r;
    out_tag_nxt       = out_tag_r;
    out_tag_valid_nxt = out_tag_valid_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (fsm_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt  = in_command;
          data_nxt = in_data_byte;
          cnt_nxt  = '0;
          case (in_command)
            tmac_pkg::CMD_START: begin
              st_nxt  = load_st;
              lim_nxt = START_LAST;
              fsm_nxt = ST_RUN;
            end
            tmac_pkg::CMD_ABSORB: begin
              lim_nxt = ABS_LAST;
              fsm_nxt = ST_RUN;
            end
            tmac_pkg::CMD_FINISH: begin
              lim_nxt = FIN_LAST;
              fsm_nxt = ST_RUN;
            end
            default: begin
              fsm_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_RUN: begin
        st_nxt  = round_out;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (squeeze) begin
          tag_nxt = {round_z, tag_r[63:1]};
        end
        if (cnt_r == lim_r) begin
          fsm_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt     = 1'b1;
          out_tag_valid_nxt = (cmd_r == tmac_pkg::CMD_FINISH);
          out_tag_nxt       = (cmd_r == tmac_pkg::CMD_FINISH) ? tag_r : '0;
          fsm_nxt           = ST_IDLE;
        end
      end
      default: begin
        fsm_nxt = ST_IDLE;
      end
    endcase
  end

  // Control, state and key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= ST_IDLE;
      cnt_r       <= '0;
      lim_r       <= '0;
      cmd_r       <= tmac_pkg::CMD_START;
      st_r        <= '0;
      out_valid_r <= 1'b0;
      key_low_r   <= '0;
      key_high_r  <= '0;
    end else begin
      fsm_r       <= fsm_nxt;
      cnt_r       <= cnt_nxt;
      lim_r       <= lim_nxt;
      cmd_r       <= cmd_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          tmac_pkg::CFG_KEY_LOW:  key_low_r  <= cfg_data;
          tmac_pkg::CFG_KEY_HIGH: key_high_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    data_r          <= data_nxt;
    tag_r           <= tag_nxt;
    out_tag_r       <= out_tag_nxt;
    out_tag_valid_r <= out_tag_valid_nxt;
  end

endmodule

FILE: rtl/tmac_checker.sv
// Port-level checker for the TRIAD-MAC tag engine and its bind.
module tmac_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_tag,
  input logic        out_tag_valid
);

  // An accepted beat keeps the input stalled while it is worked on
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accepted beat");

  // A new result beat only comes out of work in progress
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result beat without work in progress");

  // A beat without a tag carries a zero tag
  a_no_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_tag_valid) |-> (out_tag == 64'd0))
    else $error("nonzero tag on a beat without tag");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_tag) && $stable(out_tag_valid)))
    else $error("stalled result beat changed");

endmodule

bind triad_mac_engine tmac_checker u_tmac_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_tag       (out_tag),
  .out_tag_valid (out_tag_valid)
);

FILE: verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the TRIAD-MAC tag engine: directed table, then random sequences.
module tb;

  localparam int PERM_ROUNDS = 1024;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int ITEM_GOAL = 600;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int TAIL_CYCLES = PERM_ROUNDS + 100;
  localparam int PROBES = 20;

  // One result beat as the block should deliver it
  typedef struct packed {
    logic [63:0] tag;
    logic        tag_valid;
  } tag_beat_t;

  // One row of the directed table; typed rows carry their result
  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  data;
    logic [63:0] nonce_lo;
    logic [31:0] nonce_hi;
    logic        typed;
    logic [63:0] tag;
    logic        tag_valid;
  } probe_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_command;
  logic [7:0]  in_data_byte;
  logic [63:0] in_nonce_low;
  logic [31:0] in_nonce_high;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_tag;
  logic        out_tag_valid;

  // Shadow of the cipher state, indexed by register position
  logic [80:1] sr_a;
  logic [88:1] sr_b;
  logic [88:1] sr_c;
  logic [63:0] key_lo_sh;
  logic [63:0] key_hi_sh;

  tag_beat_t   pending_tags[$];
  probe_row_t  probe_table [PROBES];
  bit          quiet;
  int          stall_hold;
  int          n_errors;
  int          n_results;
  int          n_key_settings;
  int          n_cmd [4];
  int          cycle_count;

  triad_mac_engine #(.PERMUTATION_ROUNDS(PERM_ROUNDS)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_data_byte(in_data_byte), .in_nonce_low(in_nonce_low), .in_nonce_high(in_nonce_high),
    .out_valid(out_valid), .out_stall(out_stall), .out_tag(out_tag),
    .out_tag_valid(out_tag_valid)
  );

  always #5 clk = ~clk;

  // One round: returns the keystream bit, shifts the three registers
  function automatic logic triad_round(input logic m);
    logic t1, t2, t3, z;
    t1 = sr_a[68] ^ sr_a[80] ^ (sr_b[85] & sr_c[85]);
    t2 = sr_b[64] ^ sr_b[88];
    t3 = sr_c[68] ^ sr_c[88];
    z  = t1 ^ t2 ^ t3;
    t1 = t1 ^ (sr_a[73] & sr_a[79]) ^ sr_b[66] ^ m;
    t2 = t2 ^ (sr_b[65] & sr_b[87]) ^ sr_c[84] ^ m;
    t3 = t3 ^ (sr_c[77] & sr_c[87]) ^ sr_a[74] ^ m;
    sr_a = {sr_a[79:1], t3};
    sr_b = {sr_b[87:1], t1};
    sr_c = {sr_c[87:1], t2};
    return z;
  endfunction

  // Full permutation: a one on the first round, zeros after
  task automatic triad_permute();
    void'(triad_round(1'b1));
    for (int i = 1; i < PERM_ROUNDS; i++) begin
      void'(triad_round(1'b0));
    end
  endtask

  // Key/nonce load; the MSB of byte j sits at position 8j+1
  task automatic triad_load(input logic [63:0] nlo, input logic [31:0] nhi);
    logic [7:0] kb [16];
    logic [7:0] nb [12];
    logic [7:0] ab [10];
    for (int i = 0; i < 8; i++) begin
      kb[i]     = key_lo_sh[8*i +: 8];
      kb[8 + i] = key_hi_sh[8*i +: 8];
      nb[i]     = nlo[8*i +: 8];
    end
    for (int i = 0; i < 4; i++) begin
      nb[8 + i] = nhi[8*i +: 8];
    end
    ab = '{nb[0], kb[4], 8'hFF, kb[3], 8'hFF, kb[2], 8'hFF, kb[1], 8'hFE, kb[0]};
    for (int j = 0; j < 11; j++) begin
      for (int b = 0; b < 8; b++) begin
        if (j < 10) begin
          sr_a[8*j + 8 - b] = ab[j][b];
        end
        sr_b[8*j + 8 - b] = nb[11 - j][b];
        sr_c[8*j + 8 - b] = kb[15 - j][b];
      end
    end
  endtask

  // Apply one command to the shadow state and work out its result
  task automatic triad_command(input logic [1:0] cmd, input logic [7:0] data,
                               input logic [63:0] nlo, input logic [31:0] nhi,
                               output logic [63:0] tag, output logic tag_valid);
    tag = '0;
    tag_valid = 1'b0;
    case (cmd)
      tmac_pkg::CMD_START: begin
        triad_load(nlo, nhi);
        triad_permute();
      end
      tmac_pkg::CMD_ABSORB: begin
        for (int i = 0; i < 8; i++) begin
          void'(triad_round(data[i]));
        end
      end
      tmac_pkg::CMD_FINISH: begin
        triad_permute();
        for (int i = 0; i < 64; i++) begin
          tag[i] = triad_round(1'b0);
        end
        tag_valid = 1'b1;
      end
      default: ;
    endcase
  endtask

  // Drive one input beat after a random gap and hold it until taken
  task automatic send_beat(input logic [1:0] cmd, input logic [7:0] data,
                           input logic [63:0] nlo, input logic [31:0] nhi,
                           input logic typed, input logic [63:0] typed_tag,
                           input logic typed_valid);
    int gap;
    logic [63:0] tg;
    logic tv;
    tag_beat_t exp_beat;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_data_byte  <= data;
    in_nonce_low  <= nlo;
    in_nonce_high <= nhi;
    do @(posedge clk); while (in_stall);
    triad_command(cmd, data, nlo, nhi, tg, tv);
    if (typed) begin
      tg = typed_tag;
      tv = typed_valid;
    end
    exp_beat.tag       = tg;
    exp_beat.tag_valid = tv;
    pending_tags = {pending_tags, exp_beat};
    n_cmd[cmd]++;
  endtask

  // Key update, only once every tag in flight has come back
  task automatic write_keys(input logic [63:0] lo, input logic [63:0] hi);
    in_valid <= 1'b0;
    while (pending_tags.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= tmac_pkg::CFG_KEY_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= tmac_pkg::CFG_KEY_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    key_lo_sh = lo;
    key_hi_sh = hi;
    n_key_settings++;
  endtask

  // Random 64-bit field, leaning on the extremes now and then
  function automatic logic [63:0] pick64();
    case ($urandom_range(0, 7))
      0: return 64'h0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly start / data / finish runs; the rest is loose command noise
  task automatic run_sequence();
    int n_ad;
    logic [63:0] nl;
    quiet = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 6) != 0) begin
      nl = pick64();
      send_beat(tmac_pkg::CMD_START, 8'($urandom), nl, 32'(pick64()), 1'b0, '0, 1'b0);
      n_ad = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 16);
      repeat (n_ad) begin
        send_beat(tmac_pkg::CMD_ABSORB, 8'($urandom), {$urandom, $urandom}, $urandom,
                  1'b0, '0, 1'b0);
      end
      send_beat(tmac_pkg::CMD_FINISH, 8'($urandom), {$urandom, $urandom}, $urandom,
                1'b0, '0, 1'b0);
    end else begin
      repeat ($urandom_range(1, 6)) begin
        send_beat(2'($urandom_range(0, 3)), 8'($urandom), pick64(), 32'(pick64()),
                  1'b0, '0, 1'b0);
      end
    end
  endtask

  // Result side: random backpressure, then field checks in order
  always @(posedge clk) begin : result_side
    tag_beat_t want;
    if (!rst_n) begin
      stall_hold = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (pending_tags.size() == 0) begin
          $error("result beat with no command waiting: tag %h tag_valid %b",
                 out_tag, out_tag_valid);
          n_errors++;
        end else begin
          want = pending_tags.pop_front();
          if (out_tag !== want.tag) begin
            $error("tag: expected %h, got %h", want.tag, out_tag);
            n_errors++;
          end
          if (out_tag_valid !== want.tag_valid) begin
            $error("tag_valid: expected %b, got %b", want.tag_valid, out_tag_valid);
            n_errors++;
          end
        end
        stall_hold = quiet ? 0 : $urandom_range(0, 10);
      end else if (out_valid && stall_hold > 0) begin
        stall_hold--;
      end
      out_stall <= (stall_hold > 0);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("triad_mac_engine: mismatch");
      $finish;
    end
  end

  initial begin
    int phase;
    logic [63:0] klo, khi;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= tmac_pkg::CFG_KEY_LOW;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    in_command    <= tmac_pkg::CMD_START;
    in_data_byte  <= '0;
    in_nonce_low  <= '0;
    in_nonce_high <= '0;
    sr_a = '0;
    sr_b = '0;
    sr_c = '0;
    key_lo_sh = '0;
    key_hi_sh = '0;
    quiet = 1'b0;

    // Directed rows; start/absorb/unused results are zero by definition
    probe_table = '{
      // absorb and finish straight out of reset
      '{tmac_pkg::CMD_ABSORB, 8'h00, 64'h0, 32'h0, 1'b1, 64'h0, 1'b0},
      '{tmac_pkg::CMD_FINISH, 8'h00, 64'h0, 32'h0, 1'b0, 64'h0, 1'b0},
      // unused code with every field at its top
      '{CMD_UNUSED, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 64'h0, 1'b0},
      '{tmac_pkg::CMD_START,  8'hFF, 64'h0, 32'h0, 1'b1, 64'h0, 1'b0},
      '{tmac_pkg::CMD_ABSORB, 8'hFF, 64'h0, 32'h0, 1'b1, 64'h0, 1'b0},
      '{tmac_pkg::CMD_ABSORB, 8'h00, 64'h0, 32'h0, 1'b1, 64'h0, 1'b0},
      '{tmac_pkg::CMD_ABSORB, 8'hA5, 64'h0, 32'h0, 1'b1, 64'h0, 1'b0},
      '{tmac_pkg::CMD_FINISH, 8'h00, 64'h0, 32'h0, 1'b0, 64'h0, 1'b0},
      // keep going from the squeezed state
      '{tmac_pkg::CMD_ABSORB, 8'h5A, 64'h0, 32'h0, 1'b1, 64'h0, 1'b0},
      '{tmac_pkg::CMD_FINISH, 8'h00, 64'h0, 32'h0, 1'b0, 64'h0, 1'b0},
      '{tmac_pkg::CMD_FINISH, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 64'h0, 1'b0},
      '{tmac_pkg::CMD_START,  8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 64'h0, 1'b0},
      '{CMD_UNUSED, 8'h00, 64'h0, 32'h0, 1'b1, 64'h0, 1'b0},
      '{tmac_pkg::CMD_ABSORB, 8'h80, 64'h0, 32'h0, 1'b1, 64'h0, 1'b0},
      '{tmac_pkg::CMD_ABSORB, 8'h01, 64'h0, 32'h0, 1'b1, 64'h0, 1'b0},
      '{tmac_pkg::CMD_FINISH, 8'h00, 64'h0, 32'h0, 1'b0, 64'h0, 1'b0},
      // byte order of the nonce, then a tag with no data at all
      '{tmac_pkg::CMD_START,  8'h00, 64'h0706_0504_0302_0100, 32'h0B0A_0908, 1'b1, 64'h0, 1'b0},
      '{tmac_pkg::CMD_FINISH, 8'h00, 64'h0, 32'h0, 1'b0, 64'h0, 1'b0},
      '{tmac_pkg::CMD_START,  8'h00, 64'h8000_0000_0000_0001, 32'h8000_0001, 1'b1, 64'h0, 1'b0},
      '{tmac_pkg::CMD_ABSORB, 8'h7F, 64'h0, 32'h0, 1'b1, 64'h0, 1'b0}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (probe_table[i]) begin
      send_beat(probe_table[i].cmd, probe_table[i].data, probe_table[i].nonce_lo,
                probe_table[i].nonce_hi, probe_table[i].typed, probe_table[i].tag,
                probe_table[i].tag_valid);
    end

    // Random phases, each under its own key
    phase = 0;
    while (n_cmd[tmac_pkg::CMD_START] + n_cmd[tmac_pkg::CMD_ABSORB] +
           n_cmd[tmac_pkg::CMD_FINISH] < PROBES + ITEM_GOAL) begin
      case (phase)
        0: begin klo = '1; khi = '1; end
        1: begin klo = '0; khi = '0; end
        2: begin klo = 64'h5555_5555_5555_5555; khi = 64'hAAAA_AAAA_AAAA_AAAA; end
        default: begin klo = {$urandom, $urandom}; khi = {$urandom, $urandom}; end
      endcase
      write_keys(klo, khi);
      repeat ($urandom_range(3, 7)) run_sequence();
      phase++;
    end

    in_valid <= 1'b0;
    while (pending_tags.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d start, %0d absorb, %0d finish and %0d unused-code beats",
             n_cmd[tmac_pkg::CMD_START], n_cmd[tmac_pkg::CMD_ABSORB],
             n_cmd[tmac_pkg::CMD_FINISH], n_cmd[CMD_UNUSED]);
    $display("%0d result beats checked under %0d key settings", n_results, n_key_settings);
    if (n_errors == 0) begin
      $display("triad_mac_engine: match");
    end else begin
      $display("triad_mac_engine: mismatch");
    end
    $finish;
  end

endmodule
